// ===== sv/feedback_queue_thread_scheduler_defines.svh =====
// Assertion macros shared by the feedback queue thread scheduler RTL.
`ifndef FEEDBACK_QUEUE_THREAD_SCHEDULER_DEFINES_SVH
`define FEEDBACK_QUEUE_THREAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FQTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FQTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fqts_pkg.sv =====
// Shared types and constants of the feedback queue thread scheduler.
package fqts_pkg;

   // Payload widths.
   localparam int TID_W   = 8;
   localparam int PRIO_W  = 3;
   localparam int LEVEL_W = 6;
   localparam int SLICE_W = 16;
   localparam int COUNT_W = 32;

   // Item kinds.
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_GET = 1'b1;

   // Control register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SLICE = 2'd2;

   // Control register reset values.
   localparam logic [SLICE_W-1:0] SLICE_BASE_RST = 16'd970;
   localparam logic [SLICE_W-1:0] SLICE_STEP_RST = 16'd130;
   localparam logic [SLICE_W-1:0] IDLE_SLICE_RST = 16'd2500;

   // Level windows of the priority classes, relative to the start of a half.
   localparam int WIN_W        = 5;
   localparam int PRIO_CLASSES = 5;
   localparam logic [PRIO_W-1:0] PRIO_BACKGROUND = 3'd4;
   localparam logic [WIN_W-1:0] WIN_LO [PRIO_CLASSES] = '{5'd0, 5'd2, 5'd8, 5'd16, 5'd24};
   localparam logic [WIN_W-1:0] WIN_HI [PRIO_CLASSES] = '{5'd1, 5'd7, 5'd15, 5'd23, 5'd31};

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_LEVEL,
      ST_ADD_LINK,
      ST_GET_HEAD,
      ST_GET_POP,
      ST_REPLY
   } state_type;

   // Fields of an add beat that steer the level update.
   typedef struct packed {
      logic [PRIO_W-1:0]  priority_req;
      logic               is_kernel;
      logic [LEVEL_W-1:0] forced_level;
      logic               early_yield;
      logic               io_yield;
   } add_req_type;

endpackage

// ===== sv/fqts_if.sv =====
// Request and response channel interfaces of the thread scheduler.
interface fqts_req_if import fqts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [TID_W-1:0]   thread_id;
   logic [PRIO_W-1:0]  priority_req;
   logic               is_kernel;
   logic [LEVEL_W-1:0] forced_level;
   logic               early_yield;
   logic               io_yield;

   modport source (
      output valid, kind, thread_id, priority_req, is_kernel, forced_level,
             early_yield, io_yield,
      input  ready
   );
   modport sink (
      input  valid, kind, thread_id, priority_req, is_kernel, forced_level,
             early_yield, io_yield,
      output ready
   );
endinterface

interface fqts_rsp_if import fqts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               thread_valid;
   logic [TID_W-1:0]   picked_thread;
   logic [SLICE_W-1:0] time_slice_us;
   logic [LEVEL_W-1:0] queue_level;
   logic [COUNT_W-1:0] dispatch_count;
   logic [COUNT_W-1:0] idle_count;

   modport source (
      output valid, thread_valid, picked_thread, time_slice_us, queue_level,
             dispatch_count, idle_count,
      input  ready
   );
   modport sink (
      input  valid, thread_valid, picked_thread, time_slice_us, queue_level,
             dispatch_count, idle_count,
      output ready
   );
endinterface

// ===== sv/fqts_level_calc.sv =====
// Queue level update of an added thread: forced level or feedback step and window clamp.
module fqts_level_calc import fqts_pkg::*; #(
   parameter int QUEUE_LEVELS = 64,
   localparam int LVL_W = $clog2(QUEUE_LEVELS)
) (
   input  add_req_type      add_req,
   input  logic             stored_valid,
   input  logic [LVL_W-1:0] stored_level,
   output logic [LVL_W-1:0] new_level
);

   localparam int EXT_W = LEVEL_W + 1;
   localparam logic [EXT_W-1:0] TOP  = EXT_W'(QUEUE_LEVELS - 1);
   localparam logic [EXT_W-1:0] HALF = EXT_W'(QUEUE_LEVELS / 2);

   logic [PRIO_W-1:0] prio;
   logic [EXT_W-1:0]  offset;
   logic [EXT_W-1:0]  lo_raw;
   logic [EXT_W-1:0]  hi_raw;
   logic [EXT_W-1:0]  lo;
   logic [EXT_W-1:0]  hi;
   logic [EXT_W-1:0]  cur;
   logic [EXT_W-1:0]  stepped;
   logic [EXT_W-1:0]  forced;
   logic [EXT_W-1:0]  result;

   // Window of the priority class, moved into the thread's half and capped at the top queue.
   always_comb begin
      prio   = (add_req.priority_req > PRIO_BACKGROUND) ? PRIO_BACKGROUND
                                                        : add_req.priority_req;
      offset = add_req.is_kernel ? '0 : HALF;
      lo_raw = offset + EXT_W'(WIN_LO[prio]);
      hi_raw = offset + EXT_W'(WIN_HI[prio]);
      lo     = (lo_raw > TOP) ? TOP : lo_raw;
      hi     = (hi_raw > TOP) ? TOP : hi_raw;
   end

   // Feedback step: a full slice moves the thread up, an I/O wait moves it down.
   always_comb begin
      cur     = stored_valid ? EXT_W'(stored_level) : '0;
      stepped = cur;
      if (!add_req.early_yield && !add_req.io_yield && (cur < TOP)) begin
         stepped = cur + EXT_W'(1);
      end
      if (add_req.io_yield && (cur != '0)) begin
         stepped = cur - EXT_W'(1);
      end
   end

   // A nonzero forced level wins over the dynamic level.
   always_comb begin
      forced = EXT_W'(add_req.forced_level);
      if (add_req.forced_level != '0) begin
         result = (forced > TOP) ? TOP : forced;
      end else if (stepped < lo) begin
         result = lo;
      end else if (stepped > hi) begin
         result = hi;
      end else begin
         result = stepped;
      end
      new_level = LVL_W'(result);
   end

endmodule

// ===== sv/feedback_queue_thread_scheduler.sv =====
// Top level of the multilevel feedback queue thread scheduler.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         valid/ready          kind, thread id, priority, yield flags
//   rsp_     out        valid/ready          thread, time slice, level, counters
//   csr_     in         write enable only    slice base, slice step, idle slice
//
// An add steps through ST_ADD_LEVEL and ST_ADD_LINK, and a get with a queued thread
// through ST_GET_HEAD and ST_GET_POP, on the way to the result register: the first step
// uses the first table read and the second uses the second read and writes back the links.
// A dropped add or a get that finds every queue empty goes through ST_REPLY alone. The
// sequencer returns to idle and accepts the next beat once the result is registered; a result
// that is not taken holds the block in its last step until the result register is free.
// Reset is synchronous; the level table uses valid bits, so no clearing pass follows reset.
`include "feedback_queue_thread_scheduler_defines.svh"

module feedback_queue_thread_scheduler import fqts_pkg::*; #(
   parameter int QUEUE_LEVELS = 64,
   parameter int MAX_THREADS  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   fqts_req_if.sink             req_chan,
   fqts_rsp_if.source           rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SLICE_W-1:0]   csr_wdata
);

   localparam int LVL_W        = $clog2(QUEUE_LEVELS);
   localparam int ID_SPACE     = 1 << TID_W;
   localparam int THREAD_DEPTH = (MAX_THREADS > ID_SPACE) ? ID_SPACE : MAX_THREADS;
   localparam int TIDX_W       = $clog2(THREAD_DEPTH);
   localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(QUEUE_LEVELS / 2);
   localparam int PROD_W       = SLICE_W + LVL_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam logic [SUM_W-1:0] SLICE_MAX = SUM_W'({SLICE_W{1'b1}});

   typedef struct packed {
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
   } qent_type;

   typedef struct packed {
      logic [TID_W-1:0] next;
      logic [LVL_W-1:0] level;
   } tent_type;

   // Queue table (head and tail per level) and thread table (link and level per thread).
   qent_type queue_mem  [QUEUE_LEVELS];
   tent_type thread_mem [THREAD_DEPTH];

   state_type          state_ff, state_in;
   logic               kind_ff;
   logic [TID_W-1:0]   tid_ff;
   add_req_type        add_req_ff;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic               lvl_load;
   logic [QUEUE_LEVELS-1:0] nonempty_ff;
   logic [THREAD_DEPTH-1:0] lvl_vld_ff;
   logic [COUNT_W-1:0] dispatch_cnt_ff;
   logic [COUNT_W-1:0] idle_cnt_ff;
   logic [SLICE_W-1:0] slice_base_ff;
   logic [SLICE_W-1:0] slice_step_ff;
   logic [SLICE_W-1:0] idle_slice_ff;

   logic               rsp_valid_ff;
   logic               rsp_thread_valid_ff, rsp_thread_valid_in;
   logic [TID_W-1:0]   rsp_picked_ff, rsp_picked_in;
   logic [SLICE_W-1:0] rsp_slice_ff, rsp_slice_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_load;

   qent_type           q_rdata_ff;
   tent_type           t_rdata_ff;
   logic [LVL_W-1:0]   q_raddr;
   logic [TIDX_W-1:0]  t_raddr;
   logic               q_we_head, q_we_tail;
   logic [LVL_W-1:0]   q_waddr;
   qent_type           q_wdata;
   logic               t_we_next, t_we_level;
   logic [TIDX_W-1:0]  t_waddr;
   tent_type           t_wdata;
   logic               map_set, map_clr;
   logic               vld_set;
   logic               dispatch_inc, idle_inc;

   logic               accept;
   logic               rsp_free;
   logic               tid_ok;
   logic               first_found;
   logic [LVL_W-1:0]   first_level;
   logic [LVL_W-1:0]   new_level;
   logic [LVL_W-1:0]   rel_level;
   logic [PROD_W-1:0]  slice_prod;
   logic [SUM_W-1:0]   slice_sum;
   logic [SLICE_W-1:0] slice_val;

   // Channel handshakes.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign tid_ok         = (32'(req_chan.thread_id) < 32'(MAX_THREADS));

   // Lowest non-empty queue.
   always_comb begin
      first_found = 1'b0;
      first_level = '0;
      for (int i = QUEUE_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            first_found = 1'b1;
            first_level = LVL_W'(i);
         end
      end
   end

   // Level of the thread being added, from its stored level and the beat's flags.
   fqts_level_calc #(
      .QUEUE_LEVELS (QUEUE_LEVELS)
   ) u_level_calc (
      .add_req      (add_req_ff),
      .stored_valid (lvl_vld_ff[tid_ff[TIDX_W-1:0]]),
      .stored_level (t_rdata_ff.level),
      .new_level    (new_level)
   );

   // Time slice of the popped level: base plus step per level within its half.
   always_comb begin
      rel_level  = (lvl_ff >= LVL_HALF) ? (lvl_ff - LVL_HALF) : lvl_ff;
      slice_prod = PROD_W'(slice_step_ff) * PROD_W'(rel_level);
      slice_sum  = SUM_W'(slice_base_ff) + SUM_W'(slice_prod);
      slice_val  = (slice_sum > SLICE_MAX) ? {SLICE_W{1'b1}} : SLICE_W'(slice_sum);
   end

   // Read addresses: held steady while a step waits for the result register.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:      q_raddr = first_level;
         ST_ADD_LEVEL: q_raddr = new_level;
         default:      q_raddr = lvl_ff;
      endcase
      unique case (state_ff)
         ST_IDLE:                 t_raddr = req_chan.thread_id[TIDX_W-1:0];
         ST_GET_HEAD, ST_GET_POP: t_raddr = q_rdata_ff.head[TIDX_W-1:0];
         default:                 t_raddr = tid_ff[TIDX_W-1:0];
      endcase
   end

   // Sequencer: next state, table writes and result values.
   always_comb begin
      state_in            = state_ff;
      lvl_in              = lvl_ff;
      lvl_load            = 1'b0;
      q_we_head           = 1'b0;
      q_we_tail           = 1'b0;
      q_waddr             = lvl_ff;
      q_wdata.head        = tid_ff;
      q_wdata.tail        = tid_ff;
      t_we_next           = 1'b0;
      t_we_level          = 1'b0;
      t_waddr             = tid_ff[TIDX_W-1:0];
      t_wdata.next        = tid_ff;
      t_wdata.level       = new_level;
      map_set             = 1'b0;
      map_clr             = 1'b0;
      vld_set             = 1'b0;
      dispatch_inc        = 1'b0;
      idle_inc            = 1'b0;
      rsp_load            = 1'b0;
      rsp_thread_valid_in = 1'b0;
      rsp_picked_in       = '0;
      rsp_slice_in        = '0;
      rsp_level_in        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lvl_in   = first_level;
               lvl_load = 1'b1;
               if (req_chan.kind == KIND_GET) begin
                  state_in = first_found ? ST_GET_HEAD : ST_REPLY;
               end else begin
                  state_in = tid_ok ? ST_ADD_LEVEL : ST_REPLY;
               end
            end
         end

         ST_ADD_LEVEL: begin
            t_we_level = 1'b1;
            vld_set    = 1'b1;
            lvl_in     = new_level;
            lvl_load   = 1'b1;
            state_in   = ST_ADD_LINK;
         end

         ST_ADD_LINK: begin
            if (rsp_free) begin
               // Append behind the old tail, or start the queue afresh.
               if (nonempty_ff[lvl_ff]) begin
                  t_we_next = 1'b1;
                  t_waddr   = q_rdata_ff.tail[TIDX_W-1:0];
               end else begin
                  q_we_head = 1'b1;
               end
               q_we_tail           = 1'b1;
               map_set             = 1'b1;
               rsp_load            = 1'b1;
               rsp_thread_valid_in = 1'b1;
               rsp_picked_in       = tid_ff;
               rsp_level_in        = LEVEL_W'(lvl_ff);
               state_in            = ST_IDLE;
            end
         end

         ST_GET_HEAD: begin
            state_in = ST_GET_POP;
         end

         ST_GET_POP: begin
            if (rsp_free) begin
               // The last thread empties the queue; otherwise its successor becomes head.
               if (q_rdata_ff.head == q_rdata_ff.tail) begin
                  map_clr = 1'b1;
               end else begin
                  q_we_head    = 1'b1;
                  q_wdata.head = t_rdata_ff.next;
               end
               dispatch_inc        = 1'b1;
               rsp_load            = 1'b1;
               rsp_thread_valid_in = 1'b1;
               rsp_picked_in       = q_rdata_ff.head;
               rsp_slice_in        = slice_val;
               rsp_level_in        = LEVEL_W'(lvl_ff);
               state_in            = ST_IDLE;
            end
         end

         ST_REPLY: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (kind_ff == KIND_GET) begin
                  idle_inc     = 1'b1;
                  rsp_slice_in = idle_slice_ff;
               end else begin
                  rsp_picked_in = tid_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table memories: registered reads, field-wise writes.
   always_ff @(posedge clock) begin
      q_rdata_ff <= queue_mem[q_raddr];
      t_rdata_ff <= thread_mem[t_raddr];
      if (q_we_head) begin
         queue_mem[q_waddr].head <= q_wdata.head;
      end
      if (q_we_tail) begin
         queue_mem[q_waddr].tail <= q_wdata.tail;
      end
      if (t_we_next) begin
         thread_mem[t_waddr].next <= t_wdata.next;
      end
      if (t_we_level) begin
         thread_mem[t_waddr].level <= t_wdata.level;
      end
   end

   // Control state, bitmap, level valid bits and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         nonempty_ff     <= '0;
         lvl_vld_ff      <= '0;
         dispatch_cnt_ff <= '0;
         idle_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (map_set) begin
            nonempty_ff[lvl_ff] <= 1'b1;
         end
         if (map_clr) begin
            nonempty_ff[lvl_ff] <= 1'b0;
         end
         if (vld_set) begin
            lvl_vld_ff[tid_ff[TIDX_W-1:0]] <= 1'b1;
         end
         if (dispatch_inc) begin
            dispatch_cnt_ff <= dispatch_cnt_ff + COUNT_W'(1);
         end
         if (idle_inc) begin
            idle_cnt_ff <= idle_cnt_ff + COUNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Beat capture and working level.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff                 <= req_chan.kind;
         tid_ff                  <= req_chan.thread_id;
         add_req_ff.priority_req <= req_chan.priority_req;
         add_req_ff.is_kernel    <= req_chan.is_kernel;
         add_req_ff.forced_level <= req_chan.forced_level;
         add_req_ff.early_yield  <= req_chan.early_yield;
         add_req_ff.io_yield     <= req_chan.io_yield;
      end
      if (lvl_load) begin
         lvl_ff <= lvl_in;
      end
   end

   // Result register; the counters are driven straight from their registers and show this beat's update.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_thread_valid_ff <= rsp_thread_valid_in;
         rsp_picked_ff       <= rsp_picked_in;
         rsp_slice_ff        <= rsp_slice_in;
         rsp_level_ff        <= rsp_level_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.thread_valid   = rsp_thread_valid_ff;
   assign rsp_chan.picked_thread  = rsp_picked_ff;
   assign rsp_chan.time_slice_us  = rsp_slice_ff;
   assign rsp_chan.queue_level    = rsp_level_ff;
   assign rsp_chan.dispatch_count = dispatch_cnt_ff;
   assign rsp_chan.idle_count     = idle_cnt_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_base_ff <= SLICE_BASE_RST;
         slice_step_ff <= SLICE_STEP_RST;
         idle_slice_ff <= IDLE_SLICE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SLICE_BASE: slice_base_ff <= csr_wdata;
            CSR_SLICE_STEP: slice_step_ff <= csr_wdata;
            CSR_IDLE_SLICE: idle_slice_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Checks on the sequencer.
   `FQTS_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, rsp_load && rsp_valid_ff, rsp_chan.ready, "result register loaded while still full")
   `FQTS_ASSERT_NEXT(a_add_marks_queue, clock, reset, (state_ff == ST_ADD_LINK) && rsp_free, nonempty_ff[$past(lvl_ff)], "appended queue not marked non-empty")
   `FQTS_ASSERT_NEXT(a_dispatch_step, clock, reset, dispatch_inc, dispatch_cnt_ff == $past(dispatch_cnt_ff) + COUNT_W'(1), "dispatch counter did not step")
   `FQTS_ASSERT_NEXT(a_idle_step, clock, reset, idle_inc, idle_cnt_ff == $past(idle_cnt_ff) + COUNT_W'(1), "idle counter did not step")

endmodule
